/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ICMP receive checker. Each use
// samples on the rising edge of clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/icmp_rc_pkg.sv */
// ----------------------------------------------------------------------------
// icmp_rc_pkg
// Types, constants and field codes shared by the ICMP receive checker.
// ----------------------------------------------------------------------------
package icmp_rc_pkg;

  // Rate limiter timing: one credit is earned per MS_PER_CREDIT milliseconds.
  localparam int unsigned MS_PER_CREDIT = 1000;
  localparam int unsigned CREDIT_CAP    = 255;

  // Elapsed time beyond CAP_MS can never earn more than the largest burst,
  // so it is clamped before the division.
  localparam int unsigned CAP_MS    = CREDIT_CAP * MS_PER_CREDIT;
  localparam int unsigned ELAPSED_W = $clog2(CAP_MS + 1);

  // Division by MS_PER_CREDIT as a multiplication by a rounded-up reciprocal.
  // With this shift the quotient is exact for every clamped elapsed value.
  localparam int unsigned DIV_SHIFT = ELAPSED_W + $clog2(MS_PER_CREDIT);
  localparam int unsigned RECIP_W   = ELAPSED_W + 1;
  localparam int unsigned PROD_W    = ELAPSED_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(MS_PER_CREDIT) - 64'd1) / 64'(MS_PER_CREDIT);
  localparam logic [RECIP_W-1:0]   RECIP       = RECIP_FULL[RECIP_W-1:0];
  localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = ELAPSED_W'(CAP_MS);

  // Register and counter values.
  localparam logic [7:0]  BURST_RESET = 8'd10;
  localparam logic [15:0] SUPP_MAX    = 16'hffff;

  // Message checks.
  localparam logic [15:0] CSUM_GOOD  = 16'hffff;
  localparam logic [47:0] BCAST_MAC  = 48'hffff_ffff_ffff;
  localparam logic [3:0]  MIN_BYTES  = 4'd8;
  localparam logic [3:0]  BYTE_SAT   = 4'd15;
  localparam logic [7:0]  TYPE_MAX   = 8'd18;

  // Word positions within the header.
  localparam logic [2:0] IDX_TYPE_CODE = 3'd0;
  localparam logic [2:0] IDX_CHECKSUM  = 3'd1;
  localparam logic [2:0] IDX_REST_HI   = 3'd2;
  localparam logic [2:0] IDX_REST_LO   = 3'd3;

  // Message types and code limits.
  localparam logic [7:0] TYPE_UNREACH      = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQ     = 8'd8;
  localparam logic [7:0] TYPE_TIME_EXCEED  = 8'd11;
  localparam logic [7:0] TYPE_TSTAMP_REQ   = 8'd13;
  localparam logic [7:0] TYPE_MASK_REQ     = 8'd17;
  localparam logic [7:0] CODE_UNREACH_LIM  = 8'd13;
  localparam logic [7:0] CODE_TIMEX_LIM    = 8'd2;

  // One bit per type that has no assigned meaning (1, 2, 6, 7, 9, 10, 15, 16).
  localparam logic [31:0] UNASSIGNED_MASK = 32'h0001_86c6;

  typedef enum logic [3:0] {
    V_SHORT      = 4'd0,
    V_ODD        = 4'd1,
    V_BADSUM     = 4'd2,
    V_UNKNOWN    = 4'd3,
    V_BCAST_DROP = 4'd4,
    V_ECHO       = 4'd5,
    V_NOTICE     = 4'd6,
    V_BAD_CODE   = 4'd7,
    V_UNASSIGNED = 4'd8
  } verdict_t;

  // Summary of one complete message, handed from the accumulator to the
  // rate limiter.
  typedef struct packed {
    verdict_t    verdict;
    logic        lim_use;
    logic        query;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [31:0] rest;
    logic [15:0] rchk;
    logic [31:0] now_ms;
  } msg_t;

endpackage

/* rtl/icmp_rc_accum.sv */
// ----------------------------------------------------------------------------
// icmp_rc_accum
// Input register, per-message word accumulator and message classifier.
// Hands one summary per message to the rate limiter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icmp_rc_accum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_word,
  input  logic               in_single_byte,
  input  logic               in_last,
  input  logic [47:0]        in_dest_mac,
  input  logic [31:0]        in_now_ms,
  output logic               m_valid,
  input  logic               m_ready,
  output icmp_rc_pkg::msg_t  m
);

  // One's-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + 16'(t[16]);
  endfunction

  // Input register.
  logic        v0_r;
  logic [15:0] word_r;
  logic        sb_r;
  logic        last_r;
  logic        bcast_r;
  logic [31:0] now_r;

  // Message state.
  logic [3:0]  bc_r;
  logic [15:0] vsum_r;
  logic [15:0] rsum_r;
  logic [15:0] tcw_r;
  logic [31:0] shw_r;
  logic        fbc_r;

  // Summary register.
  logic              m_valid_r;
  icmp_rc_pkg::msg_t m_r;

  logic              accept;
  logic              s0_go;
  logic              m_free;
  logic              odd;
  logic [15:0]       w;
  logic [2:0]        idx;
  logic [15:0]       tcw_nxt;
  logic [31:0]       shw_nxt;
  logic              fbc_nxt;
  logic [15:0]       vsum_nxt;
  logic [15:0]       rsum_nxt;
  logic [4:0]        bc_sum;
  logic [3:0]        bc_nxt;
  logic [7:0]        tval;
  logic [7:0]        code;
  logic              passed;
  icmp_rc_pkg::msg_t m_nxt;

  // Handshake: a non-last beat leaves freely, a last beat needs a free summary slot.
  assign m_free   = !m_valid_r || m_ready;
  assign s0_go    = v0_r && (!last_r || m_free);
  assign in_ready = !v0_r || s0_go;
  assign accept   = in_valid && in_ready;

  // Word as added: an odd last beat carries only its upper byte.
  assign odd = last_r && sb_r;
  assign w   = odd ? {word_r[15:8], 8'h00} : word_r;
  assign idx = bc_r[3:1];

  // Header capture and running sums for this beat.
  always_comb begin
    tcw_nxt  = tcw_r;
    fbc_nxt  = fbc_r;
    shw_nxt  = shw_r;
    if (idx == icmp_rc_pkg::IDX_TYPE_CODE) begin
      tcw_nxt = w;
      fbc_nxt = bcast_r;
    end else if (idx == icmp_rc_pkg::IDX_REST_HI) begin
      shw_nxt = {w, shw_r[15:0]};
    end else if (idx == icmp_rc_pkg::IDX_REST_LO) begin
      shw_nxt = {shw_r[31:16], w};
    end

    vsum_nxt = oc_add(vsum_r, w);
    if (idx == icmp_rc_pkg::IDX_TYPE_CODE) begin
      rsum_nxt = oc_add(rsum_r, {8'h00, w[7:0]});
    end else if (idx == icmp_rc_pkg::IDX_CHECKSUM) begin
      rsum_nxt = rsum_r;
    end else begin
      rsum_nxt = oc_add(rsum_r, w);
    end

    bc_sum = {1'b0, bc_r} + (odd ? 5'd1 : 5'd2);
    bc_nxt = (bc_sum > {1'b0, icmp_rc_pkg::BYTE_SAT}) ? icmp_rc_pkg::BYTE_SAT : bc_sum[3:0];
  end

  // Classification of the completed message.
  assign tval = tcw_nxt[15:8];
  assign code = tcw_nxt[7:0];

  always_comb begin
    passed          = 1'b0;
    m_nxt.msg_type  = tval;
    m_nxt.msg_code  = code;
    m_nxt.rest      = shw_nxt;
    m_nxt.now_ms    = now_r;
    m_nxt.query     = (tval == icmp_rc_pkg::TYPE_ECHO_REQ) ||
                      (tval == icmp_rc_pkg::TYPE_TSTAMP_REQ) ||
                      (tval == icmp_rc_pkg::TYPE_MASK_REQ);
    m_nxt.rchk      = 16'h0000;
    if (bc_nxt < icmp_rc_pkg::MIN_BYTES) begin
      m_nxt.verdict = icmp_rc_pkg::V_SHORT;
    end else if (odd) begin
      m_nxt.verdict = icmp_rc_pkg::V_ODD;
    end else if (vsum_nxt != icmp_rc_pkg::CSUM_GOOD) begin
      m_nxt.verdict = icmp_rc_pkg::V_BADSUM;
    end else if (tval > icmp_rc_pkg::TYPE_MAX) begin
      m_nxt.verdict = icmp_rc_pkg::V_UNKNOWN;
    end else begin
      passed = 1'b1;
      if (tval == icmp_rc_pkg::TYPE_ECHO_REQ) begin
        m_nxt.verdict = icmp_rc_pkg::V_ECHO;
        // A sum of all ones folds to zero first, so the result is never zero.
        m_nxt.rchk    = (rsum_nxt == 16'hffff) ? 16'hffff : ~rsum_nxt;
      end else if (((tval == icmp_rc_pkg::TYPE_UNREACH) &&
                    (code >= icmp_rc_pkg::CODE_UNREACH_LIM)) ||
                   ((tval == icmp_rc_pkg::TYPE_TIME_EXCEED) &&
                    (code >= icmp_rc_pkg::CODE_TIMEX_LIM))) begin
        m_nxt.verdict = icmp_rc_pkg::V_BAD_CODE;
      end else if (icmp_rc_pkg::UNASSIGNED_MASK[tval[4:0]]) begin
        m_nxt.verdict = icmp_rc_pkg::V_UNASSIGNED;
      end else begin
        m_nxt.verdict = icmp_rc_pkg::V_NOTICE;
      end
    end
    m_nxt.lim_use = passed && fbc_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      m_valid_r <= 1'b0;
      bc_r      <= '0;
      vsum_r    <= '0;
      rsum_r    <= '0;
      tcw_r     <= '0;
      shw_r     <= '0;
      fbc_r     <= 1'b0;
    end else begin
      if (accept) begin
        v0_r <= 1'b1;
      end else if (s0_go) begin
        v0_r <= 1'b0;
      end

      if (s0_go && last_r) begin
        m_valid_r <= 1'b1;
      end else if (m_ready) begin
        m_valid_r <= 1'b0;
      end

      // Message state returns to zero after the last beat.
      if (s0_go) begin
        if (last_r) begin
          bc_r   <= '0;
          vsum_r <= '0;
          rsum_r <= '0;
          tcw_r  <= '0;
          shw_r  <= '0;
          fbc_r  <= 1'b0;
        end else begin
          bc_r   <= bc_nxt;
          vsum_r <= vsum_nxt;
          rsum_r <= rsum_nxt;
          tcw_r  <= tcw_nxt;
          shw_r  <= shw_nxt;
          fbc_r  <= fbc_nxt;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r  <= in_word;
      sb_r    <= in_single_byte;
      last_r  <= in_last;
      bcast_r <= (in_dest_mac == icmp_rc_pkg::BCAST_MAC);
      now_r   <= in_now_ms;
    end
    if (s0_go && last_r) begin
      m_r <= m_nxt;
    end
  end

  assign m_valid = m_valid_r;
  assign m       = m_r;

  `ASSERT_NEXT(a_state_clear_after_last, s0_go && last_r, (bc_r == '0) && (vsum_r == '0), "message state not cleared after last beat")
  `ASSERT_PROP(a_limiter_only_on_pass, m_valid_r && m_r.lim_use |-> m_r.verdict > icmp_rc_pkg::V_BCAST_DROP, "limiter requested for a failed message")

endmodule

/* rtl/icmp_rc_limiter.sv */
// ----------------------------------------------------------------------------
// icmp_rc_limiter
// Token-bucket rate limiter for broadcast messages and the result register.
// Three stages: elapsed time, credits earned, credit decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icmp_rc_limiter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         burst_limit,
  input  logic               m_valid,
  output logic               m_ready,
  input  icmp_rc_pkg::msg_t  m,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_verdict,
  output logic [7:0]         out_msg_type,
  output logic [7:0]         out_msg_code,
  output logic [31:0]        out_rest_of_header,
  output logic [15:0]        out_reply_checksum,
  output logic               out_log_allowed,
  output logic [15:0]        out_suppressed_reported
);

  // Elapsed stage.
  logic                               e_valid_r;
  icmp_rc_pkg::msg_t                  e_msg_r;
  logic [icmp_rc_pkg::ELAPSED_W-1:0]  e_elapsed_r;
  logic [31:0]                        lgt_r;

  // Quotient stage.
  logic              q_valid_r;
  icmp_rc_pkg::msg_t q_msg_r;
  logic [7:0]        q_quot_r;

  // Limiter state.
  logic [7:0]  credit_r;
  logic [15:0] supp_r;

  // Result register.
  logic                  out_valid_r;
  icmp_rc_pkg::verdict_t out_verdict_r;
  logic [7:0]            out_type_r;
  logic [7:0]            out_code_r;
  logic [31:0]           out_rest_r;
  logic [15:0]           out_rchk_r;
  logic                  out_allowed_r;
  logic [15:0]           out_supp_r;

  logic                               out_free;
  logic                               q_free;
  logic                               e_free;
  logic                               q_go;
  logic                               e_go;
  logic                               m_go;
  logic [31:0]                        elapsed;
  logic [icmp_rc_pkg::ELAPSED_W-1:0]  elapsed_clamp;
  logic [icmp_rc_pkg::PROD_W-1:0]     prod;
  logic [8:0]                         cred_sum;
  logic [7:0]                         creds;
  logic                               grant;

  // Stage handshakes.
  assign out_free = !out_valid_r || !out_stall;
  assign q_free   = !q_valid_r || out_free;
  assign e_free   = !e_valid_r || q_free;
  assign q_go     = q_valid_r && out_free;
  assign e_go     = e_valid_r && q_free;
  assign m_go     = m_valid && e_free;
  assign m_ready  = e_free;

  // Time since the limiter was last used, clamped to what can matter.
  assign elapsed       = m.now_ms - lgt_r;
  assign elapsed_clamp = (elapsed > 32'(icmp_rc_pkg::ELAPSED_CAP)) ?
                         icmp_rc_pkg::ELAPSED_CAP :
                         elapsed[icmp_rc_pkg::ELAPSED_W-1:0];

  // Credits earned: elapsed divided by the credit period via its reciprocal.
  assign prod = icmp_rc_pkg::PROD_W'(e_elapsed_r) * icmp_rc_pkg::PROD_W'(icmp_rc_pkg::RECIP);

  // Credit decision, capped at the burst limit.
  assign cred_sum = {1'b0, credit_r} + {1'b0, q_quot_r};
  assign creds    = (cred_sum > {1'b0, burst_limit}) ? burst_limit : cred_sum[7:0];
  assign grant    = (creds != 8'd0);

  // Control and limiter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      lgt_r       <= '0;
      credit_r    <= icmp_rc_pkg::BURST_RESET;
      supp_r      <= '0;
    end else begin
      if (m_go) begin
        e_valid_r <= 1'b1;
      end else if (e_go) begin
        e_valid_r <= 1'b0;
      end

      if (e_go) begin
        q_valid_r <= 1'b1;
      end else if (q_go) begin
        q_valid_r <= 1'b0;
      end

      if (q_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (m_go && m.lim_use) begin
        lgt_r <= m.now_ms;
      end

      if (q_go && q_msg_r.lim_use) begin
        if (grant) begin
          credit_r <= creds - 8'd1;
          supp_r   <= '0;
        end else begin
          credit_r <= '0;
          if (supp_r != icmp_rc_pkg::SUPP_MAX) begin
            supp_r <= supp_r + 16'd1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (m_go) begin
      e_msg_r     <= m;
      e_elapsed_r <= elapsed_clamp;
    end
    if (e_go) begin
      q_msg_r  <= e_msg_r;
      q_quot_r <= prod[icmp_rc_pkg::DIV_SHIFT +: 8];
    end
    if (q_go) begin
      out_type_r    <= q_msg_r.msg_type;
      out_code_r    <= q_msg_r.msg_code;
      out_rest_r    <= q_msg_r.rest;
      out_rchk_r    <= q_msg_r.rchk;
      out_allowed_r <= q_msg_r.lim_use && grant;
      out_supp_r    <= (q_msg_r.lim_use && grant) ? supp_r : 16'h0000;
      // An error-class broadcast is dropped whatever the limiter decides.
      out_verdict_r <= (q_msg_r.lim_use && !q_msg_r.query) ?
                       icmp_rc_pkg::V_BCAST_DROP : q_msg_r.verdict;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_verdict             = out_verdict_r;
  assign out_msg_type            = out_type_r;
  assign out_msg_code            = out_code_r;
  assign out_rest_of_header      = out_rest_r;
  assign out_reply_checksum      = out_rchk_r;
  assign out_log_allowed         = out_allowed_r;
  assign out_suppressed_reported = out_supp_r;

  `ASSERT_PROP(a_release_needs_grant, out_valid_r && (out_supp_r != '0) |-> out_allowed_r, "suppressed count released without a grant")
  `ASSERT_PROP(a_rchk_only_on_echo, out_valid_r |-> (out_verdict_r == icmp_rc_pkg::V_ECHO) == (out_rchk_r != '0), "reply checksum and echo verdict disagree")
  `ASSERT_NEXT(a_grant_clears_supp, q_go && q_msg_r.lim_use && grant, supp_r == '0, "suppressed count not cleared on grant")

endmodule

/* rtl/icmp_receive_checker_unit.sv */
// ----------------------------------------------------------------------------
// icmp_receive_checker_unit
// ICMP receive checker: checksum, length and type checks with a broadcast
// rate limiter.
// ----------------------------------------------------------------------------
// The block takes one 16-bit message word per cycle while in_stall is low,
// with no gaps needed between words or messages, and returns one result per
// message. The last word passes through the input register, the summary
// register of the word accumulator and classifier, and the elapsed, quotient
// and result registers of the rate limiter, whose credit division is a
// reciprocal multiply registered in a stage of its own. Non-last words give
// no result. The burst limit register may be written at any time the block
// is idle; the block needs no start-up sweep after reset.
// ----------------------------------------------------------------------------
module icmp_receive_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_packet_word,
  input  logic        in_single_byte,
  input  logic        in_last_word,
  input  logic [47:0] in_dest_mac,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_verdict,
  output logic [7:0]  out_msg_type,
  output logic [7:0]  out_msg_code,
  output logic [31:0] out_rest_of_header,
  output logic [15:0] out_reply_checksum,
  output logic        out_log_allowed,
  output logic [15:0] out_suppressed_reported
);

  logic [7:0]        burst_limit_r;
  logic              in_ready;
  logic              m_valid;
  logic              m_ready;
  icmp_rc_pkg::msg_t m;

  // Burst limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r <= icmp_rc_pkg::BURST_RESET;
    end else if (cfg_wr_en) begin
      burst_limit_r <= cfg_wr_data;
    end
  end

  assign in_stall = !in_ready;

  // Word accumulation and classification.
  icmp_rc_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_packet_word),
    .in_single_byte (in_single_byte),
    .in_last        (in_last_word),
    .in_dest_mac    (in_dest_mac),
    .in_now_ms      (in_now_ms),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m              (m)
  );

  // Broadcast rate limiting and result register.
  icmp_rc_limiter u_limiter (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .burst_limit             (burst_limit_r),
    .m_valid                 (m_valid),
    .m_ready                 (m_ready),
    .m                       (m),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_verdict             (out_verdict),
    .out_msg_type            (out_msg_type),
    .out_msg_code            (out_msg_code),
    .out_rest_of_header      (out_rest_of_header),
    .out_reply_checksum      (out_reply_checksum),
    .out_log_allowed         (out_log_allowed),
    .out_suppressed_reported (out_suppressed_reported)
  );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// ICMP receive checker testbench
// Drives ICMP messages word by word into icmp_receive_checker_unit and checks
// every per-message result against an in-bench model of the checksum,
// length and type checks and of the broadcast token-bucket limiter.
// A short directed set is followed by random phases under different burst
// limits and idling patterns, then a short zero-burst run whose suppressed
// count a later grant releases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Protocol values used by the predictor, kept apart from the RTL package.
  localparam logic [7:0]  ICMP_DEST_UNREACH  = 8'd3;
  localparam logic [7:0]  ICMP_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0]  ICMP_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0]  ICMP_TIMESTAMP     = 8'd13;
  localparam logic [7:0]  ICMP_ADDR_MASK     = 8'd17;
  localparam logic [7:0]  ICMP_TYPE_LAST     = 8'd18;
  localparam logic [7:0]  UNREACH_CODES      = 8'd13;
  localparam logic [7:0]  TIMEX_CODES        = 8'd2;
  localparam logic [31:0] UNASSIGNED_TYPES   = (32'd1 << 1) | (32'd1 << 2) | (32'd1 << 6) |
                                               (32'd1 << 7) | (32'd1 << 9) | (32'd1 << 10) |
                                               (32'd1 << 15) | (32'd1 << 16);
  localparam logic [47:0] ALL_ONES_MAC       = 48'hffff_ffff_ffff;
  localparam logic [15:0] SUM_OK             = 16'hffff;
  localparam logic [15:0] SUPPRESS_CAP       = 16'hffff;
  localparam logic [7:0]  BURST_AT_RESET     = 8'd10;
  localparam int          CREDIT_MS          = 1000;
  localparam int          MIN_MSG_BYTES      = 8;
  localparam int          BYTE_CAP           = 15;
  localparam int          SETTLE_CYCLES      = 16;
  localparam int          WORDS_PER_PHASE    = 220;
  localparam int          FLOOD_MESSAGES     = 8;

  typedef struct packed {
    logic [15:0] word;
    logic        single;
    logic        last;
    logic [47:0] mac;
    logic [31:0] stamp;
  } beat_t;

  typedef struct packed {
    icmp_rc_pkg::verdict_t verdict;
    logic [7:0]            msg_type;
    logic [7:0]            msg_code;
    logic [31:0]           rest;
    logic [15:0]           rchk;
    logic                  allowed;
    logic [15:0]           released;
  } verdict_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_packet_word = 16'd0;
  logic        in_single_byte = 1'b0;
  logic        in_last_word = 1'b0;
  logic [47:0] in_dest_mac = 48'd0;
  logic [31:0] in_now_ms = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_verdict;
  logic [7:0]  out_msg_type;
  logic [7:0]  out_msg_code;
  logic [31:0] out_rest_of_header;
  logic [15:0] out_reply_checksum;
  logic        out_log_allowed;
  logic [15:0] out_suppressed_reported;

  icmp_receive_checker_unit u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_packet_word          (in_packet_word),
    .in_single_byte          (in_single_byte),
    .in_last_word            (in_last_word),
    .in_dest_mac             (in_dest_mac),
    .in_now_ms               (in_now_ms),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_verdict             (out_verdict),
    .out_msg_type            (out_msg_type),
    .out_msg_code            (out_msg_code),
    .out_rest_of_header      (out_rest_of_header),
    .out_reply_checksum      (out_reply_checksum),
    .out_log_allowed         (out_log_allowed),
    .out_suppressed_reported (out_suppressed_reported)
  );

  // Stimulus and expectation stores.
  beat_t        pending_beats[$];
  verdict_rec_t awaited_verdicts[$];
  beat_t        on_wire;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic [31:0]  stamp_ms = 32'd0;

  // Predictor state: message accumulator and rate limiter.
  logic [7:0]   burst_cfg = BURST_AT_RESET;
  logic [3:0]   msg_bytes = 4'd0;
  logic [15:0]  check_sum = 16'd0;
  logic [15:0]  echo_sum = 16'd0;
  logic [15:0]  head_word = 16'd0;
  logic [31:0]  rest_word = 32'd0;
  logic         from_bcast = 1'b0;
  logic [7:0]   credits = BURST_AT_RESET;
  logic [15:0]  suppressed = 16'd0;
  logic [31:0]  last_use_ms = 32'd0;

  // Run statistics.
  int beats_sent = 0;
  int results_checked = 0;
  int grants = 0;
  int suppressions = 0;
  int mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // One's-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // A link address that is never the broadcast one.
  function automatic logic [47:0] unicast_mac();
    if ($urandom_range(0, 3) == 0) begin
      return ALL_ONES_MAC ^ (48'd1 << $urandom_range(0, 47));
    end
    return {16'($urandom), 32'($urandom)} & ~(48'd1 << $urandom_range(0, 47));
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Advances the model by one accepted beat and records any result it causes.
  task automatic classify_beat(input beat_t b);
    logic [15:0]  w;
    logic         odd;
    logic [2:0]   idx;
    logic [7:0]   ty;
    logic [7:0]   cd;
    logic [31:0]  elapsed;
    logic [15:0]  folded;
    int unsigned  creds;
    int           next_bytes;
    bit           query;
    bit           dropped;
    verdict_rec_t r;

    odd = b.last && b.single;
    w = odd ? {b.word[15:8], 8'h00} : b.word;
    idx = msg_bytes[3:1];

    // Capture the header words by position.
    if (idx == icmp_rc_pkg::IDX_TYPE_CODE) begin
      head_word = w;
      from_bcast = (b.mac == ALL_ONES_MAC);
    end else if (idx == icmp_rc_pkg::IDX_REST_HI) begin
      rest_word[31:16] = w;
    end else if (idx == icmp_rc_pkg::IDX_REST_LO) begin
      rest_word[15:0] = w;
    end

    // The reply sum sees type 0 and a zero checksum field.
    check_sum = ones_add(check_sum, w);
    if (idx == icmp_rc_pkg::IDX_TYPE_CODE) begin
      echo_sum = ones_add(echo_sum, {8'h00, w[7:0]});
    end else if (idx != icmp_rc_pkg::IDX_CHECKSUM) begin
      echo_sum = ones_add(echo_sum, w);
    end

    next_bytes = int'(msg_bytes) + (odd ? 1 : 2);
    msg_bytes = (next_bytes > BYTE_CAP) ? 4'(BYTE_CAP) : 4'(next_bytes);
    if (!b.last) begin
      return;
    end

    ty = head_word[15:8];
    cd = head_word[7:0];
    r.msg_type = ty;
    r.msg_code = cd;
    r.rest = rest_word;
    r.rchk = 16'd0;
    r.allowed = 1'b0;
    r.released = 16'd0;

    if (msg_bytes < MIN_MSG_BYTES) begin
      r.verdict = icmp_rc_pkg::V_SHORT;
    end else if (odd) begin
      r.verdict = icmp_rc_pkg::V_ODD;
    end else if (check_sum != SUM_OK) begin
      r.verdict = icmp_rc_pkg::V_BADSUM;
    end else if (ty > ICMP_TYPE_LAST) begin
      r.verdict = icmp_rc_pkg::V_UNKNOWN;
    end else begin
      query = (ty == ICMP_ECHO_REQUEST) || (ty == ICMP_TIMESTAMP) || (ty == ICMP_ADDR_MASK);
      dropped = 1'b0;
      // Token bucket: credits earned since the previous use, capped at the burst.
      if (from_bcast) begin
        elapsed = b.stamp - last_use_ms;
        creds = int'(credits) + elapsed / CREDIT_MS;
        last_use_ms = b.stamp;
        if (creds > burst_cfg) begin
          creds = burst_cfg;
        end
        if (creds >= 1) begin
          r.allowed = 1'b1;
          r.released = suppressed;
          suppressed = 16'd0;
          credits = 8'(creds - 1);
          grants++;
        end else begin
          credits = 8'd0;
          if (suppressed != SUPPRESS_CAP) begin
            suppressed++;
          end
          suppressions++;
        end
        dropped = !query;
      end
      if (dropped) begin
        r.verdict = icmp_rc_pkg::V_BCAST_DROP;
      end else if (ty == ICMP_ECHO_REQUEST) begin
        folded = (echo_sum == 16'hffff) ? 16'd0 : echo_sum;
        r.rchk = ~folded;
        r.verdict = icmp_rc_pkg::V_ECHO;
      end else if ((ty == ICMP_DEST_UNREACH && cd >= UNREACH_CODES) ||
                   (ty == ICMP_TIME_EXCEEDED && cd >= TIMEX_CODES)) begin
        r.verdict = icmp_rc_pkg::V_BAD_CODE;
      end else if (UNASSIGNED_TYPES[ty[4:0]]) begin
        r.verdict = icmp_rc_pkg::V_UNASSIGNED;
      end else begin
        r.verdict = icmp_rc_pkg::V_NOTICE;
      end
    end
    awaited_verdicts.push_back(r);

    // The accumulator starts afresh for the next message.
    msg_bytes = 4'd0;
    check_sum = 16'd0;
    echo_sum = 16'd0;
    head_word = 16'd0;
    rest_word = 32'd0;
    from_bcast = 1'b0;
  endtask

  task automatic check_result();
    verdict_rec_t e;
    if (awaited_verdicts.size() == 0) begin
      flag_mismatch($sformatf("result with none awaited, verdict %0d", out_verdict));
      return;
    end
    e = awaited_verdicts.pop_front();
    if (out_verdict !== e.verdict) begin
      flag_mismatch($sformatf("result %0d verdict %0d, want %0d", results_checked,
                              out_verdict, e.verdict));
    end
    if (out_msg_type !== e.msg_type) begin
      flag_mismatch($sformatf("result %0d type %0d, want %0d", results_checked,
                              out_msg_type, e.msg_type));
    end
    if (out_msg_code !== e.msg_code) begin
      flag_mismatch($sformatf("result %0d code %0d, want %0d", results_checked,
                              out_msg_code, e.msg_code));
    end
    if (out_rest_of_header !== e.rest) begin
      flag_mismatch($sformatf("result %0d rest %h, want %h", results_checked,
                              out_rest_of_header, e.rest));
    end
    if (out_reply_checksum !== e.rchk) begin
      flag_mismatch($sformatf("result %0d reply checksum %h, want %h", results_checked,
                              out_reply_checksum, e.rchk));
    end
    if (out_log_allowed !== e.allowed) begin
      flag_mismatch($sformatf("result %0d log allowed %b, want %b", results_checked,
                              out_log_allowed, e.allowed));
    end
    if (out_suppressed_reported !== e.released) begin
      flag_mismatch($sformatf("result %0d suppressed %0d, want %0d", results_checked,
                              out_suppressed_reported, e.released));
    end
    results_checked++;
  endtask

  // Builds one message and queues its beats. A good sum makes the message
  // add up to all ones; odd_end sends the last beat as a single byte and
  // mid_single flags a single byte on a beat that is not the last.
  task automatic queue_message(input logic [15:0] head, input logic [31:0] rest, input int n,
                               input bit bcast, input bit good_sum, input bit odd_end,
                               input bit mid_single, input logic [31:0] stamp);
    logic [15:0] w[0:15];
    logic [15:0] s;
    beat_t       b;
    int          mid_at;
    int          i;
    w[0] = head;
    w[1] = 16'd0;
    w[2] = rest[31:16];
    w[3] = rest[15:0];
    for (i = 4; i < n; i++) begin
      w[i] = 16'($urandom);
    end
    s = 16'd0;
    for (i = 0; i < n; i++) begin
      if (i != 1) begin
        s = ones_add(s, (odd_end && i == n - 1) ? {w[i][15:8], 8'h00} : w[i]);
      end
    end
    w[1] = ~s;
    if (!good_sum) begin
      w[1] = w[1] ^ 16'($urandom_range(1, 65535));
    end
    mid_at = (mid_single && n > 1) ? $urandom_range(0, n - 2) : -1;
    for (i = 0; i < n; i++) begin
      b.word = w[i];
      b.last = (i == n - 1);
      b.single = b.last ? odd_end : (i == mid_at);
      if (i == 0) begin
        b.mac = bcast ? ALL_ONES_MAC : unicast_mac();
      end else begin
        b.mac = ($urandom_range(0, 3) == 0) ? ALL_ONES_MAC : unicast_mac();
      end
      b.stamp = b.last ? stamp : $urandom;
      pending_beats.push_back(b);
    end
  endtask

  // Random message, mostly well formed, with the clock moved on first.
  task automatic queue_random_message(output int n);
    int          roll;
    logic [7:0]  ty;
    logic [7:0]  cd;
    roll = $urandom_range(0, 99);
    n = (roll < 8) ? $urandom_range(1, 3) : (roll < 85) ? $urandom_range(4, 7) :
        $urandom_range(8, 12);
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      ty = 8'($urandom_range(0, ICMP_TYPE_LAST));
    end else if (roll < 82) begin
      ty = $urandom_range(0, 1) ? ICMP_DEST_UNREACH : ICMP_TIME_EXCEEDED;
    end else if (roll < 92) begin
      ty = ICMP_ECHO_REQUEST;
    end else begin
      ty = 8'($urandom);
    end
    if ($urandom_range(0, 3) == 0) begin
      cd = 8'($urandom);
    end else if (ty == ICMP_DEST_UNREACH) begin
      cd = 8'($urandom_range(10, 15));
    end else begin
      cd = 8'($urandom_range(0, 3));
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      stamp_ms = stamp_ms + $urandom_range(0, 999);
    end else if (roll < 85) begin
      stamp_ms = stamp_ms + $urandom_range(1000, 4000);
    end else if (roll < 95) begin
      stamp_ms = stamp_ms + $urandom_range(0, 300000);
    end else begin
      stamp_ms = $urandom;
    end
    queue_message({ty, cd}, $urandom, n, $urandom_range(0, 99) < 45,
                  $urandom_range(0, 99) < 88, $urandom_range(0, 99) < 8,
                  $urandom_range(0, 99) < 8, stamp_ms);
  endtask

  // Waits until every queued beat has gone and every result has come back,
  // then lets the pipeline settle.
  task automatic drain_all();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || awaited_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_burst(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    burst_cfg = value;
    @(negedge clk);
  endtask

  // Input driver: presents the next queued beat once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        classify_beat(on_wire);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_packet_word <= on_wire.word;
          in_single_byte <= on_wire.single;
          in_last_word <= on_wire.last;
          in_dest_mac <= on_wire.mac;
          in_now_ms <= on_wire.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Sequence of phases.
  initial begin
    int         phase;
    int         words;
    int         n;
    int         k;
    logic [7:0] setting;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed messages under the reset burst limit.
    queue_message({ICMP_ECHO_REQUEST, 8'h00}, 32'hffff_0000, 4, 1, 1, 0, 0, 32'd0);
    queue_message(16'hffff, 32'd0, 1, 0, 1, 1, 0, 32'd0);
    queue_message({ICMP_TIME_EXCEEDED, TIMEX_CODES}, 32'h1234_5678, 4, 0, 1, 0, 1, 32'd0);
    queue_message({ICMP_DEST_UNREACH, 8'h00}, 32'hdead_beef, 5, 0, 1, 1, 0, 32'd0);
    queue_message(16'hff00, 32'd0, 4, 0, 0, 0, 0, 32'd0);
    queue_message({ICMP_TYPE_LAST + 8'd1, 8'h00}, 32'd0, 4, 0, 1, 0, 0, 32'd0);
    queue_message({ICMP_DEST_UNREACH, UNREACH_CODES}, 32'd0, 4, 1, 1, 0, 0, 32'hffff_ffff);
    drain_all();
    stamp_ms = 32'hffff_ffff;

    // Random phases, each with its own burst limit and idling pattern.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          setting = 8'd1;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          setting = 8'd255;
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          setting = 8'd3;
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          setting = 8'($urandom_range(1, 255));
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      write_burst(setting);
      words = 0;
      while (words < WORDS_PER_PHASE) begin
        queue_random_message(n);
        words += n;
      end
      drain_all();
    end

    // A zero burst suppresses every broadcast; a later grant then releases
    // the count gathered meanwhile.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_burst(8'd0);
    for (k = 0; k < FLOOD_MESSAGES; k++) begin
      queue_message({ICMP_ECHO_REQUEST, 8'(k)}, $urandom, 4, 1, 1, 0, 0, stamp_ms);
    end
    drain_all();
    write_burst(8'd2);
    queue_message({ICMP_ADDR_MASK, 8'h00}, $urandom, 4, 1, 1, 0, 0, stamp_ms + 32'd5000);
    drain_all();

    $display("Covered %0d beats and %0d results over burst limits 10, 1, 255, 3, a random one, 0, 2.",
             beats_sent, results_checked);
    $display("The limiter granted %0d times and suppressed %0d; %0d mismatches.",
             grants, suppressions, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #15ms;
    $display("testbench failed");
    $finish;
  end

endmodule

/* icmp_receive_checker_unit.f */
+incdir+rtl
rtl/icmp_rc_pkg.sv
rtl/icmp_rc_accum.sv
rtl/icmp_rc_limiter.sv
rtl/icmp_receive_checker_unit.sv
verif/testbench.sv
